FILE: hdl/slbc_pkg.sv
// ----------------------------------------------------------------------------
// slbc_pkg: status LED blink controller shared definitions
// Opcodes, phase encoding, pattern codes, register indexes, pattern tables
// and the colour scaling helper.
// ----------------------------------------------------------------------------
package slbc_pkg;

	localparam int WIN_W   = 11;   // window register width
	localparam int BR_W    = 8;    // brightness width
	localparam int CHK_W   = 7;    // chunk / recheck register width
	localparam int PHASE_W = 11;   // phase countdown width (max 1875)
	localparam int PAT_W   = 3;
	localparam int LVL_W   = 8;
	localparam int IDX_W   = 3;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_SET_MODE = 2'd1,
		OP_ACTIVITY = 2'd2,
		OP_ERROR    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_DECIDE = 2'd0,
		PH_LIT    = 2'd1,
		PH_DARK   = 2'd2,
		PH_OFF    = 2'd3
	} phase_t;

	typedef enum logic [IDX_W-1:0] {
		REG_ERROR_WINDOW    = 3'd0,
		REG_ACTIVITY_WINDOW = 3'd1,
		REG_NORMAL_BRIGHT   = 3'd2,
		REG_ERROR_BRIGHT    = 3'd3,
		REG_OFF_CHECK       = 3'd4,
		REG_DARK_RECHECK    = 3'd5
	} reg_idx_t;

	localparam logic [PAT_W-1:0] PAT_OFF   = 3'd0;
	localparam logic [PAT_W-1:0] PAT_IDLE  = 3'd1;
	localparam logic [PAT_W-1:0] PAT_ADV   = 3'd2;
	localparam logic [PAT_W-1:0] PAT_TX    = 3'd3;
	localparam logic [PAT_W-1:0] PAT_RESET = 3'd4;
	localparam logic [PAT_W-1:0] PAT_ERR   = 3'd5;

	localparam logic [WIN_W-1:0] ERROR_WINDOW_RST    = 11'd1000;
	localparam logic [WIN_W-1:0] ACTIVITY_WINDOW_RST = 11'd600;
	localparam logic [BR_W-1:0]  NORMAL_BRIGHT_RST   = 8'd32;
	localparam logic [BR_W-1:0]  ERROR_BRIGHT_RST    = 8'd64;
	localparam logic [CHK_W-1:0] OFF_CHECK_RST       = 7'd50;
	localparam logic [CHK_W-1:0] DARK_RECHECK_RST    = 7'd100;

	typedef struct packed {
		logic [LVL_W-1:0] r;
		logic [LVL_W-1:0] g;
		logic [LVL_W-1:0] b;
	} color_t;

	// Unused mode codes show as idle.
	function automatic logic [PAT_W-1:0] pattern_of(input logic [PAT_W-1:0] m);
		pattern_of = (m > PAT_ERR) ? PAT_IDLE : m;
	endfunction

	function automatic color_t pat_color(input logic [PAT_W-1:0] p);
		case (p)
			PAT_IDLE:  pat_color = '{r: 8'd0,   g: 8'd255, b: 8'd0};
			PAT_ADV:   pat_color = '{r: 8'd0,   g: 8'd200, b: 8'd255};
			PAT_TX:    pat_color = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
			PAT_RESET: pat_color = '{r: 8'd220, g: 8'd0,   b: 8'd255};
			PAT_ERR:   pat_color = '{r: 8'd255, g: 8'd0,   b: 8'd0};
			default:   pat_color = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
		endcase
	endfunction

	function automatic logic [PHASE_W-1:0] lit_ms(input logic [PAT_W-1:0] p);
		case (p)
			PAT_IDLE:  lit_ms = 11'd125;
			PAT_ADV:   lit_ms = 11'd63;
			PAT_TX:    lit_ms = 11'd42;
			PAT_RESET: lit_ms = 11'd62;
			PAT_ERR:   lit_ms = 11'd50;
			default:   lit_ms = 11'd1;
		endcase
	endfunction

	function automatic logic [PHASE_W-1:0] dark_ms(input logic [PAT_W-1:0] p);
		case (p)
			PAT_IDLE:  dark_ms = 11'd1875;
			PAT_ADV:   dark_ms = 11'd937;
			PAT_TX:    dark_ms = 11'd291;
			PAT_RESET: dark_ms = 11'd438;
			PAT_ERR:   dark_ms = 11'd150;
			default:   dark_ms = 11'd1;
		endcase
	endfunction

	// round(c*br/255); x/255 == (x + (x>>8) + 1) >> 8 for x up to 65534,
	// and here x never exceeds 255*255+127
	function automatic logic [LVL_W-1:0] scale(input logic [LVL_W-1:0] c,
	                                           input logic [BR_W-1:0] br);
		logic [15:0] x;
		logic [16:0] y;
		x = ({8'd0, c} * {8'd0, br}) + 16'd127;
		y = 17'(x) + 17'(x[15:8]) + 17'd1;
		scale = y[15:8];
	endfunction

endpackage

FILE: hdl/status_led_blink_controller.sv
// ----------------------------------------------------------------------------
// status_led_blink_controller: status LED pattern sequencer
// Path: an accepted item updates the state and has its pattern captured in
// stage 1; colour scaling then loads the output reg once that is free or
// being drained, and the result waits there for out_ready.
// Throughput: one item per cycle unless out_ready stalls; the intermediate
// stage lets an item in while the previous result still waits on out_ready.
// Reset (arst_n low, asynchronous): registers to their defaults, mode idle,
// pattern decided at the first tick, age counters saturated, no result pending.
// ----------------------------------------------------------------------------
module status_led_blink_controller
	import slbc_pkg::*;
#(
	parameter int AGE_BITS = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration write port
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [WIN_W-1:0] cfg_data,
	// item input
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       opcode,
	input  logic [PAT_W-1:0] mode,
	// result output
	output logic             out_valid,
	input  logic             out_ready,
	output logic [LVL_W-1:0] red_level,
	output logic [LVL_W-1:0] green_level,
	output logic [LVL_W-1:0] blue_level,
	output logic             lit,
	output logic [PAT_W-1:0] shown_pattern
);

	localparam int CMP_W = (AGE_BITS > WIN_W) ? AGE_BITS : WIN_W;
	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	// ---------------- configuration registers ----------------
	logic [WIN_W-1:0] error_window_q, activity_window_q;
	logic [BR_W-1:0]  normal_bright_q, error_bright_q;
	logic [CHK_W-1:0] off_check_q, dark_recheck_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_window_q    <= ERROR_WINDOW_RST;
			activity_window_q <= ACTIVITY_WINDOW_RST;
			normal_bright_q   <= NORMAL_BRIGHT_RST;
			error_bright_q    <= ERROR_BRIGHT_RST;
			off_check_q       <= OFF_CHECK_RST;
			dark_recheck_q    <= DARK_RECHECK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ERROR_WINDOW:    error_window_q    <= cfg_data;
				REG_ACTIVITY_WINDOW: activity_window_q <= cfg_data;
				REG_NORMAL_BRIGHT:   normal_bright_q   <= cfg_data[BR_W-1:0];
				REG_ERROR_BRIGHT:    error_bright_q    <= cfg_data[BR_W-1:0];
				REG_OFF_CHECK:       off_check_q       <= cfg_data[CHK_W-1:0];
				REG_DARK_RECHECK:    dark_recheck_q    <= cfg_data[CHK_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- sequencer state ----------------
	logic [PAT_W-1:0]    sel_mode_q, shown_q;
	phase_t              phase_q;
	logic [PHASE_W-1:0]  phase_left_q;
	logic [CHK_W-1:0]    chunk_left_q;
	logic                err_seen_q, act_seen_q;
	logic [AGE_BITS-1:0] err_age_q, act_age_q;

	logic [PAT_W-1:0]    sel_mode_d, shown_d;
	phase_t              phase_d;
	logic [PHASE_W-1:0]  phase_left_d;
	logic [CHK_W-1:0]    chunk_left_d;
	logic                err_seen_d, act_seen_d;
	logic [AGE_BITS-1:0] err_age_d, act_age_d;
	logic                lit_d;

	// pipeline handshake
	logic in_xfer;
	logic valid_s1, s1_adv;
	logic out_valid_q;

	// s1 moves on when the output register is empty or being drained
	assign s1_adv   = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || s1_adv;
	assign in_xfer  = in_valid && in_ready;

	// Next-state logic: one item (tick or event) applied to the state.
	always_comb begin
		logic [AGE_BITS-1:0] ea, aa;
		logic                err_open, act_open;
		logic [CHK_W-1:0]    chk;
		logic [PHASE_W-1:0]  chk_w;
		logic [PAT_W-1:0]    pick;

		sel_mode_d   = sel_mode_q;
		shown_d      = shown_q;
		phase_d      = phase_q;
		phase_left_d = phase_left_q;
		chunk_left_d = chunk_left_q;
		err_seen_d   = err_seen_q;
		act_seen_d   = act_seen_q;
		err_age_d    = err_age_q;
		act_age_d    = act_age_q;

		// ages after this tick's increment (saturating)
		ea = (err_age_q != AGE_MAX) ? err_age_q + 1'b1 : err_age_q;
		aa = (act_age_q != AGE_MAX) ? act_age_q + 1'b1 : act_age_q;
		// window open only while seen and age unsaturated and below length
		err_open = err_seen_q && (ea != AGE_MAX) &&
		           (CMP_W'(ea) < CMP_W'(error_window_q));
		act_open = act_seen_q && (aa != AGE_MAX) &&
		           (CMP_W'(aa) < CMP_W'(activity_window_q));
		// zero chunk length acts as one
		chk   = (off_check_q != '0) ? off_check_q : CHK_W'(1);
		chk_w = PHASE_W'(chk);
		pick  = PAT_IDLE;

		case (op_t'(opcode))
			OP_TICK: begin
				err_age_d = ea;
				act_age_d = aa;
				case (phase_q)
					PH_LIT: begin
						if (phase_left_q != '0) phase_left_d = phase_left_q - 1'b1;
						if (phase_left_d == '0) begin
							phase_d      = PH_DARK;
							phase_left_d = dark_ms(shown_q);
							chunk_left_d = (chk_w < phase_left_d) ? chk
							                                      : phase_left_d[CHK_W-1:0];
						end
					end
					PH_DARK: begin
						if (phase_left_q != '0) phase_left_d = phase_left_q - 1'b1;
						if (chunk_left_q != '0) chunk_left_d = chunk_left_q - 1'b1;
						// chunk boundary: end early on error, or activity when not tx
						if (chunk_left_d == '0) begin
							if (phase_left_d == '0 || err_open ||
							    (act_open && shown_q != PAT_TX))
								phase_d = PH_DECIDE;
							else
								chunk_left_d = (chk_w < phase_left_d) ? chk
								                                      : phase_left_d[CHK_W-1:0];
						end
					end
					PH_OFF: begin
						if (phase_left_q != '0) phase_left_d = phase_left_q - 1'b1;
						if (phase_left_d == '0) phase_d = PH_DECIDE;
					end
					default: ;
				endcase
				if (phase_d == PH_DECIDE) begin
					if (err_open)      pick = PAT_ERR;
					else if (act_open) pick = PAT_TX;
					else               pick = pattern_of(sel_mode_q);
					shown_d = pick;
					if (pick == PAT_OFF) begin
						phase_d      = PH_OFF;
						phase_left_d = (dark_recheck_q != '0) ? PHASE_W'(dark_recheck_q)
						                                      : PHASE_W'(1);
					end else begin
						phase_d      = PH_LIT;
						phase_left_d = lit_ms(pick);
					end
				end
			end
			OP_SET_MODE: sel_mode_d = mode;
			OP_ACTIVITY: begin
				act_seen_d = 1'b1;
				act_age_d  = '0;
			end
			OP_ERROR: begin
				err_seen_d = 1'b1;
				err_age_d  = '0;
			end
			default: ;
		endcase
	end

	// Output decode of the sequencer state.
	assign lit_d = (phase_d == PH_LIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_mode_q   <= PAT_IDLE;
			shown_q      <= PAT_IDLE;
			phase_q      <= PH_DECIDE;
			phase_left_q <= '0;
			chunk_left_q <= '0;
			err_seen_q   <= 1'b0;
			act_seen_q   <= 1'b0;
			err_age_q    <= AGE_MAX;
			act_age_q    <= AGE_MAX;
		end else if (in_xfer) begin
			sel_mode_q   <= sel_mode_d;
			shown_q      <= shown_d;
			phase_q      <= phase_d;
			phase_left_q <= phase_left_d;
			chunk_left_q <= chunk_left_d;
			err_seen_q   <= err_seen_d;
			act_seen_q   <= act_seen_d;
			err_age_q    <= err_age_d;
			act_age_q    <= act_age_d;
		end
	end

	// ---------------- stage 1: pattern and lit flag ----------------
	logic [PAT_W-1:0] pat_s1;
	logic             lit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pat_s1 <= shown_d;
			lit_s1 <= lit_d;
		end
	end

	// ---------------- stage 2: colour scaling into output ----------------
	color_t           col;
	logic [BR_W-1:0]  br;
	logic [LVL_W-1:0] red_q, green_q, blue_q;
	logic             lit_q;
	logic [PAT_W-1:0] pat_q;

	// error pattern has its own brightness; dark shows black
	assign col = pat_color(pat_s1);
	assign br  = (pat_s1 == PAT_ERR) ? error_bright_q : normal_bright_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			red_q   <= lit_s1 ? scale(col.r, br) : '0;
			green_q <= lit_s1 ? scale(col.g, br) : '0;
			blue_q  <= lit_s1 ? scale(col.b, br) : '0;
			lit_q   <= lit_s1;
			pat_q   <= pat_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign red_level     = red_q;
	assign green_level   = green_q;
	assign blue_level    = blue_q;
	assign lit           = lit_q;
	assign shown_pattern = pat_q;

	// ---------------- assertions ----------------
	// a lit phase always has time left on it
	a_lit_has_time: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LIT |-> phase_left_q != '0)
		else $error("lit phase with zero time left");

	// a dark result carries no colour
	a_dark_black: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !lit) |-> (red_level == '0 && green_level == '0 &&
		                         blue_level == '0))
		else $error("dark result with nonzero colour");

	// only defined pattern codes are shown
	a_pat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> shown_pattern <= PAT_ERR)
		else $error("shown pattern out of range");

	// taking an item while stage 1 is full requires stage 1 to move on
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && valid_s1) |-> s1_adv)
		else $error("stage 1 overwritten");

endmodule

FILE: tb/status_led_blink_controller_test.sv
// ----------------------------------------------------------------------------
// status_led_blink_controller_test: self-checking bench for the LED sequencer
// A short table of hand-picked items runs first, then bursts of 1 ms ticks
// mixed with mode, activity and error reports under several register
// settings and handshake pressures. Every result transfer is compared field
// by field with a typed row's result or a cycle-free blink sequencer model.
// ----------------------------------------------------------------------------
module status_led_blink_controller_test;
	timeunit 1ns;
	timeprecision 1ps;

	import slbc_pkg::*;

	localparam int AGE_W = 11;
	localparam logic [AGE_W-1:0] AGE_SAT = '1;
	localparam int HOLD_OFF_CYCLES = 64;

	// per-pattern tables, indexed by pattern code (off .. error)
	localparam logic [5:0][23:0] PAT_RGB = {24'hFF0000, 24'hDC00FF, 24'h0000FF,
		24'h00C8FF, 24'h00FF00, 24'h000000};
	localparam logic [5:0][10:0] LIT_TICKS = {11'd50, 11'd62, 11'd42, 11'd63,
		11'd125, 11'd1};
	localparam logic [5:0][10:0] DARK_TICKS = {11'd150, 11'd438, 11'd291,
		11'd937, 11'd1875, 11'd1};

	typedef struct packed {
		logic [LVL_W-1:0] red;
		logic [LVL_W-1:0] green;
		logic [LVL_W-1:0] blue;
		logic             glow;
		logic [PAT_W-1:0] shown;
	} led_result_t;

	typedef struct packed {
		op_t              op;
		logic [PAT_W-1:0] mode;
		logic             typed;  // want holds a hand-written result
		led_result_t      want;
	} stim_row_t;

	typedef struct {
		int unsigned err_win;
		int unsigned act_win;
		int unsigned norm_br;
		int unsigned err_br;
		int unsigned off_chk;
		int unsigned recheck;
	} reg_plan_t;

	// hand-written results, reset register values
	localparam led_result_t NO_CHECK  = '0;
	localparam led_result_t DARK_IDLE = '{8'd0, 8'd0, 8'd0, 1'b0, PAT_IDLE};
	localparam led_result_t TX_DIM    = '{8'd0, 8'd0, 8'd32, 1'b1, PAT_TX};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [WIN_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       opcode = OP_TICK;
	logic [PAT_W-1:0] mode = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [LVL_W-1:0] red_level;
	logic [LVL_W-1:0] green_level;
	logic [LVL_W-1:0] blue_level;
	logic             lit;
	logic [PAT_W-1:0] shown_pattern;

	// travels with the payload so the monitor knows whether a row is typed
	logic             row_typed = 1'b0;
	led_result_t      row_want = '0;

	led_result_t      pending_colors [$];
	int               fail_count = 0;
	int               sender_idle_pct = 0;
	int               rx_stall_pct = 0;
	int               hold_requests = 0;
	int               hold_served = 0;
	int               hold_left = 0;

	// ---------------------------------------------------------------
	// Sequencer model: register shadows and state
	// ---------------------------------------------------------------
	logic [WIN_W-1:0] sh_err_win;
	logic [WIN_W-1:0] sh_act_win;
	logic [BR_W-1:0]  sh_norm_br;
	logic [BR_W-1:0]  sh_err_br;
	logic [CHK_W-1:0] sh_off_chk;
	logic [CHK_W-1:0] sh_recheck;

	logic [PAT_W-1:0] sel_mode;
	logic [PAT_W-1:0] shown_pat;
	phase_t           blink_phase;
	logic [10:0]      phase_left;
	logic [CHK_W-1:0] chunk_left;
	logic             err_seen;
	logic             act_seen;
	logic [AGE_W-1:0] err_age;
	logic [AGE_W-1:0] act_age;

	stim_row_t directed_rows [20] = '{
		// events before the first tick: dark, idle shown
		'{OP_SET_MODE, 3'd7, 1'b1, DARK_IDLE},
		'{OP_SET_MODE, 3'd0, 1'b1, DARK_IDLE},
		'{OP_ACTIVITY, 3'd5, 1'b1, DARK_IDLE},
		// first tick decides: fresh activity forces transmitting over "off"
		'{OP_TICK,     3'd2, 1'b1, TX_DIM},
		// reports mid-phase change nothing until the next decision
		'{OP_ERROR,    3'd0, 1'b1, TX_DIM},
		'{OP_SET_MODE, 3'd5, 1'b1, TX_DIM},
		'{OP_TICK,     3'd7, 1'b1, TX_DIM},
		'{OP_SET_MODE, 3'd1, 1'b0, NO_CHECK},
		'{OP_TICK,     3'd0, 1'b0, NO_CHECK},
		'{OP_SET_MODE, 3'd2, 1'b0, NO_CHECK},
		'{OP_SET_MODE, 3'd3, 1'b0, NO_CHECK},
		'{OP_TICK,     3'd4, 1'b0, NO_CHECK},
		'{OP_SET_MODE, 3'd4, 1'b0, NO_CHECK},
		'{OP_SET_MODE, 3'd6, 1'b0, NO_CHECK},
		'{OP_TICK,     3'd1, 1'b0, NO_CHECK},
		'{OP_ACTIVITY, 3'd2, 1'b0, NO_CHECK},
		'{OP_ERROR,    3'd7, 1'b0, NO_CHECK},
		'{OP_TICK,     3'd3, 1'b0, NO_CHECK},
		'{OP_SET_MODE, 3'd7, 1'b0, NO_CHECK},
		'{OP_TICK,     3'd6, 1'b0, NO_CHECK}
	};

	status_led_blink_controller #(
		.AGE_BITS(AGE_W)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.mode         (mode),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red_level    (red_level),
		.green_level  (green_level),
		.blue_level   (blue_level),
		.lit          (lit),
		.shown_pattern(shown_pattern)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void reset_model();
		sh_err_win  = ERROR_WINDOW_RST;
		sh_act_win  = ACTIVITY_WINDOW_RST;
		sh_norm_br  = NORMAL_BRIGHT_RST;
		sh_err_br   = ERROR_BRIGHT_RST;
		sh_off_chk  = OFF_CHECK_RST;
		sh_recheck  = DARK_RECHECK_RST;
		sel_mode    = PAT_IDLE;
		shown_pat   = PAT_IDLE;
		blink_phase = PH_DECIDE;
		phase_left  = '0;
		chunk_left  = '0;
		err_seen    = 1'b0;
		act_seen    = 1'b0;
		err_age     = AGE_SAT;
		act_age     = AGE_SAT;
	endfunction

	function automatic void shadow_write(reg_idx_t idx, logic [WIN_W-1:0] val);
		case (idx)
			REG_ERROR_WINDOW:    sh_err_win = val;
			REG_ACTIVITY_WINDOW: sh_act_win = val;
			REG_NORMAL_BRIGHT:   sh_norm_br = val[BR_W-1:0];
			REG_ERROR_BRIGHT:    sh_err_br  = val[BR_W-1:0];
			REG_OFF_CHECK:       sh_off_chk = val[CHK_W-1:0];
			REG_DARK_RECHECK:    sh_recheck = val[CHK_W-1:0];
			default: ;
		endcase
	endfunction

	// a saturated age is always a closed window
	function automatic bit error_window_open();
		return err_seen && err_age != AGE_SAT && err_age < sh_err_win;
	endfunction

	function automatic bit activity_window_open();
		return act_seen && act_age != AGE_SAT && act_age < sh_act_win;
	endfunction

	// off_check of zero counts as 1; a chunk never runs past the phase end
	function automatic logic [CHK_W-1:0] next_chunk();
		int unsigned c;
		c = (sh_off_chk != 0) ? sh_off_chk : 1;
		return (c < phase_left) ? CHK_W'(c) : CHK_W'(phase_left);
	endfunction

	function automatic void choose_pattern();
		logic [PAT_W-1:0] p;
		if (error_window_open())
			p = PAT_ERR;
		else if (activity_window_open())
			p = PAT_TX;
		else
			p = (sel_mode > PAT_ERR) ? PAT_IDLE : sel_mode;
		shown_pat = p;
		if (p == PAT_OFF) begin
			blink_phase = PH_OFF;
			phase_left  = (sh_recheck != 0) ? 11'(sh_recheck) : 11'd1;
		end else begin
			blink_phase = PH_LIT;
			phase_left  = LIT_TICKS[p];
		end
	endfunction

	function automatic void advance_ms();
		if (err_age != AGE_SAT) err_age++;
		if (act_age != AGE_SAT) act_age++;
		case (blink_phase)
			PH_LIT: begin
				if (phase_left != 0) phase_left--;
				if (phase_left == 0) begin
					blink_phase = PH_DARK;
					phase_left  = DARK_TICKS[shown_pat];
					chunk_left  = next_chunk();
				end
			end
			PH_DARK: begin
				if (phase_left != 0) phase_left--;
				if (chunk_left != 0) chunk_left--;
				if (chunk_left == 0) begin
					// early exit on an open error window, or on activity unless
					// transmitting is already on show
					if (phase_left == 0 || error_window_open() ||
					    (activity_window_open() && shown_pat != PAT_TX))
						blink_phase = PH_DECIDE;
					else
						chunk_left = next_chunk();
				end
			end
			PH_OFF: begin
				if (phase_left != 0) phase_left--;
				if (phase_left == 0) blink_phase = PH_DECIDE;
			end
			default: ;
		endcase
		if (blink_phase == PH_DECIDE) choose_pattern();
	endfunction

	function automatic logic [LVL_W-1:0] scale_level(logic [7:0] c, logic [BR_W-1:0] br);
		int unsigned prod;
		prod = c * br + 127;
		return LVL_W'(prod / 255);
	endfunction

	// one input item in, the color on show after it out
	function automatic led_result_t apply_item(op_t op, logic [PAT_W-1:0] m);
		led_result_t res;
		logic [BR_W-1:0] br;
		logic [23:0] rgb;
		case (op)
			OP_TICK:     advance_ms();
			OP_SET_MODE: sel_mode = m;
			OP_ACTIVITY: begin
				act_seen = 1'b1;
				act_age  = '0;
			end
			default: begin
				err_seen = 1'b1;
				err_age  = '0;
			end
		endcase
		res = '0;
		res.shown = shown_pat;
		if (blink_phase == PH_LIT) begin
			// brightness is read live, so a register change shows at once
			br  = (shown_pat == PAT_ERR) ? sh_err_br : sh_norm_br;
			rgb = PAT_RGB[shown_pat];
			res.red   = scale_level(rgb[23:16], br);
			res.green = scale_level(rgb[15:8], br);
			res.blue  = scale_level(rgb[7:0], br);
			res.glow  = 1'b1;
		end
		return res;
	endfunction

	// ---------------------------------------------------------------
	// Monitor: register writes, input transfers and result transfers
	// all sampled at the clock edge they happen on.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : monitor
		led_result_t want;
		led_result_t got;
		if (arst_n) begin
			if (cfg_we) shadow_write(reg_idx_t'(cfg_index), cfg_data);
			if (in_valid && in_ready) begin
				want = apply_item(op_t'(opcode), mode);
				if (row_typed) want = row_want;
				pending_colors.push_back(want);
			end
			if (out_valid && out_ready) begin
				got = '{red_level, green_level, blue_level, lit, shown_pattern};
				if (pending_colors.size() == 0) begin
					$error("result transfer with no result expected");
					fail_count++;
				end else begin
					want = pending_colors.pop_front();
					if (got.red !== want.red) begin
						$error("red_level: expected %0d, got %0d", want.red, got.red);
						fail_count++;
					end
					if (got.green !== want.green) begin
						$error("green_level: expected %0d, got %0d", want.green, got.green);
						fail_count++;
					end
					if (got.blue !== want.blue) begin
						$error("blue_level: expected %0d, got %0d", want.blue, got.blue);
						fail_count++;
					end
					if (got.glow !== want.glow) begin
						$error("lit: expected %0d, got %0d", want.glow, got.glow);
						fail_count++;
					end
					if (got.shown !== want.shown) begin
						$error("shown_pattern: expected %0d, got %0d", want.shown,
							got.shown);
						fail_count++;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off on request so the
	// sender fills the pipeline and sees in_ready drop.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served++;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Offer one item and hold it until the transfer, then maybe go idle.
	task automatic send_item(op_t op, logic [PAT_W-1:0] m, logic typed,
	                         led_result_t want);
		in_valid  <= 1'b1;
		opcode    <= op;
		mode      <= m;
		row_typed <= typed;
		row_want  <= want;
		do @(posedge clk); while (!in_ready);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stop offering and wait for every outstanding result to come back.
	// Every item yields a result, so an empty queue means the block is idle.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_colors.size() != 0);
	endtask

	task automatic write_reg(reg_idx_t idx, int unsigned val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= WIN_W'(val);
		@(posedge clk);
	endtask

	task automatic apply_plan(reg_plan_t plan);
		write_reg(REG_ERROR_WINDOW, plan.err_win);
		write_reg(REG_ACTIVITY_WINDOW, plan.act_win);
		write_reg(REG_NORMAL_BRIGHT, plan.norm_br);
		write_reg(REG_ERROR_BRIGHT, plan.err_br);
		write_reg(REG_OFF_CHECK, plan.off_chk);
		write_reg(REG_DARK_RECHECK, plan.recheck);
		cfg_we <= 1'b0;
	endtask

	// Mostly runs of ticks so phases actually roll over, with reports and
	// mode changes sprinkled in. Payload bits that the opcode ignores are
	// randomized anyway.
	task automatic run_phase(reg_plan_t plan, int tx_idle, int rx_stall,
	                         bit squeeze, int budget);
		int sent;
		int pick;
		int burst;
		apply_plan(plan);
		sender_idle_pct = tx_idle;
		rx_stall_pct    = rx_stall;
		if (squeeze) hold_requests <= hold_requests + 1;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				burst = $urandom_range(1, 25);
				repeat (burst) send_item(OP_TICK, PAT_W'($urandom_range(7)), 1'b0,
					NO_CHECK);
				sent += burst;
			end else begin
				if (pick < 82)
					send_item(OP_SET_MODE, PAT_W'($urandom_range(7)), 1'b0, NO_CHECK);
				else if (pick < 92)
					send_item(OP_ACTIVITY, PAT_W'($urandom_range(7)), 1'b0, NO_CHECK);
				else
					send_item(OP_ERROR, PAT_W'($urandom_range(7)), 1'b0, NO_CHECK);
				sent++;
			end
		end
		settle();
	endtask

	initial begin
		reg_plan_t plan;
		reset_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, reset register values
		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].mode,
				directed_rows[i].typed, directed_rows[i].want);
		settle();

		// widest error window, activity window 1 (never opens), full brightness,
		// zero chunk/recheck (acts as 1); no idling, long receiver hold-off first
		plan = '{2000, 1, 255, 255, 0, 0};
		run_phase(plan, 0, 0, 1'b1, 230);

		// narrowest error window (never opens), zero brightness, longest chunks
		plan = '{1, 2000, 0, 0, 127, 127};
		run_phase(plan, 59, 0, 1'b0, 230);

		plan = '{150, 80, 128, 200, 10, 5};
		run_phase(plan, 0, 59, 1'b0, 230);

		plan = '{$urandom_range(1, 2000), $urandom_range(1, 2000),
			$urandom_range(255), $urandom_range(255),
			$urandom_range(1, 127), $urandom_range(1, 127)};
		run_phase(plan, 26, 26, 1'b0, 230);

		// back to the reset values
		plan = '{1000, 600, 32, 64, 50, 100};
		run_phase(plan, 0, 0, 1'b0, 230);

		// let any stray result show up before the verdict
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
hdl/slbc_pkg.sv
hdl/status_led_blink_controller.sv
tb/status_led_blink_controller_test.sv
